// ----- rtl/quaternion_vector_rotate_core_assert.svh -----
// Assertion macros for the quaternion vector rotation core.
// Included by files that check their own logic; depends on nothing else.
`ifndef QUATERNION_VECTOR_ROTATE_CORE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define QVR_ASSERT_IMPLIES(label, clk, rst_n, cond, concl) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (concl)) \
        else $error("assertion failed");

`define QVR_ASSERT_NEXT(label, clk, rst_n, cond, concl) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (concl)) \
        else $error("assertion failed");

`else

`define QVR_ASSERT_IMPLIES(label, clk, rst_n, cond, concl)

`define QVR_ASSERT_NEXT(label, clk, rst_n, cond, concl)

`endif

`endif

// ----- rtl/qvr_pkg.sv -----
// Package for the quaternion vector rotation core.
// Holds component codes and operand selection tables; depends on nothing.
`default_nettype none

package qvr_pkg;

    localparam int OUT_WIDTH = 20;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;
    localparam logic [1:0] COMP_W = 2'd3;

    // Products of the first Hamilton product, three per component of t.
    localparam logic [1:0] FIRST_Q_SEL [12] = '{
        COMP_W, COMP_Y, COMP_Z,
        COMP_W, COMP_Z, COMP_X,
        COMP_W, COMP_X, COMP_Y,
        COMP_X, COMP_Y, COMP_Z
    };
    localparam logic [1:0] FIRST_V_SEL [12] = '{
        COMP_X, COMP_Z, COMP_Y,
        COMP_Y, COMP_X, COMP_Z,
        COMP_Z, COMP_Y, COMP_X,
        COMP_X, COMP_Y, COMP_Z
    };

    // Products of the second Hamilton product, four per result component;
    // the first two terms add and the last two subtract.
    localparam logic [1:0] SECOND_T_SEL [12] = '{
        COMP_X, COMP_Z, COMP_W, COMP_Y,
        COMP_Y, COMP_X, COMP_W, COMP_Z,
        COMP_Z, COMP_Y, COMP_W, COMP_X
    };
    localparam logic [1:0] SECOND_Q_SEL [12] = '{
        COMP_W, COMP_Y, COMP_X, COMP_Z,
        COMP_W, COMP_Z, COMP_Y, COMP_X,
        COMP_W, COMP_X, COMP_Z, COMP_Y
    };

endpackage

`default_nettype wire

// ----- rtl/quaternion_vector_rotate_core.sv -----
// Top level of the quaternion vector rotation core: a six-stage pipeline.
// Depends on qvr_pkg and quaternion_vector_rotate_core_assert.svh.
`default_nettype none

// Rotates a vector by a Q2.F quaternion as q * (v, 0) * conj(q) and returns
// the vector part, rounded to nearest with ties upwards and saturated to
// signed 20 bits; clamped marks any saturated component. The quaternion is
// not normalised, so the result scales by its squared norm. An item is taken
// in every cycle while in_stall is low and passes through the product, sum,
// product, partial sum, rounding and saturation registers, one stage for each.
// Bubbles close up under a stall, so the input stalls only once all six
// stages hold items and the output is stalled.
module quaternion_vector_rotate_core #(
    parameter int VEC_WIDTH      = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [QUAT_FRAC_BITS+1:0] quat_x,
    input  wire logic signed [QUAT_FRAC_BITS+1:0] quat_y,
    input  wire logic signed [QUAT_FRAC_BITS+1:0] quat_z,
    input  wire logic signed [QUAT_FRAC_BITS+1:0] quat_w,
    input  wire logic signed [VEC_WIDTH-1:0]   vec_x,
    input  wire logic signed [VEC_WIDTH-1:0]   vec_y,
    input  wire logic signed [VEC_WIDTH-1:0]   vec_z,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [qvr_pkg::OUT_WIDTH-1:0] rot_x,
    output logic signed [qvr_pkg::OUT_WIDTH-1:0] rot_y,
    output logic signed [qvr_pkg::OUT_WIDTH-1:0] rot_z,
    output logic                               clamped
);

    import qvr_pkg::*;

`include "quaternion_vector_rotate_core_assert.svh"

    localparam int QW    = QUAT_FRAC_BITS + 2;
    localparam int PW    = QW + VEC_WIDTH;
    localparam int TW    = PW + 2;
    localparam int LW    = (TW + 1) / 2;
    localparam int HW    = TW - LW;
    localparam int PHW   = HW + QW;
    localparam int PLW   = LW + 1 + QW;
    localparam int HSW   = PHW + 2;
    localparam int LSW   = PLW + 2;
    localparam int RW    = TW + QW + 3;
    localparam int DROP  = 2 * QUAT_FRAC_BITS;
    localparam int SW    = (RW > DROP + OUT_WIDTH + 1) ? RW : DROP + OUT_WIDTH + 1;
    localparam int NW    = SW - DROP;
    localparam int STAGES = 6;

    localparam logic signed [SW-1:0] HALF  = SW'(1) <<< (DROP - 1);
    localparam logic signed [NW-1:0] MAX_V = NW'((2 ** (OUT_WIDTH - 1)) - 1);
    localparam logic signed [NW-1:0] MIN_V = -MAX_V - NW'(1);

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] en;

    logic signed [QW-1:0]  q_in [4];
    logic signed [VEC_WIDTH-1:0] v_in [3];

    logic signed [QW-1:0]  qa_reg [4];
    logic signed [PW-1:0]  pa_reg [12];
    logic signed [PW-1:0]  pa_next [12];

    logic signed [QW-1:0]  qb_reg [4];
    logic signed [TW-1:0]  tb_reg [4];
    logic signed [TW-1:0]  tb_next [4];

    logic signed [PHW-1:0] ph_reg [12];
    logic signed [PHW-1:0] ph_next [12];
    logic signed [PLW-1:0] pl_reg [12];
    logic signed [PLW-1:0] pl_next [12];

    logic signed [HSW-1:0] hs_reg [3];
    logic signed [HSW-1:0] hs_next [3];
    logic signed [LSW-1:0] ls_reg [3];
    logic signed [LSW-1:0] ls_next [3];

    logic signed [NW-1:0]  rn_reg [3];
    logic signed [NW-1:0]  rn_next [3];

    logic signed [OUT_WIDTH-1:0] rot_reg [3];
    logic signed [OUT_WIDTH-1:0] rot_next [3];
    logic                        clamped_reg;
    logic                        clamped_next;
    logic                        at_limit;

    always_comb
    begin
        en[STAGES-1] = !v_reg[STAGES-1] || !out_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign q_in[COMP_X] = quat_x;
    assign q_in[COMP_Y] = quat_y;
    assign q_in[COMP_Z] = quat_z;
    assign q_in[COMP_W] = quat_w;
    assign v_in[COMP_X] = vec_x;
    assign v_in[COMP_Y] = vec_y;
    assign v_in[COMP_Z] = vec_z;

    always_comb
    begin
        for (int i = 0; i < 12; i++)
        begin
            pa_next[i] = PW'(q_in[FIRST_Q_SEL[i]]) * PW'(v_in[FIRST_V_SEL[i]]);
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            tb_next[c] = TW'(pa_reg[3*c]) + TW'(pa_reg[3*c+1]) - TW'(pa_reg[3*c+2]);
        end
        tb_next[COMP_W] = -(TW'(pa_reg[9]) + TW'(pa_reg[10]) + TW'(pa_reg[11]));
    end

    always_comb
    begin
        logic signed [TW-1:0]  t_sel;
        logic signed [PHW-1:0] t_hi;
        logic signed [PLW-1:0] t_lo;
        for (int i = 0; i < 12; i++)
        begin
            t_sel      = tb_reg[SECOND_T_SEL[i]];
            t_hi       = PHW'($signed(t_sel[TW-1:LW]));
            t_lo       = PLW'($signed({1'b0, t_sel[LW-1:0]}));
            ph_next[i] = t_hi * PHW'(qb_reg[SECOND_Q_SEL[i]]);
            pl_next[i] = t_lo * PLW'(qb_reg[SECOND_Q_SEL[i]]);
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            hs_next[c] = HSW'(ph_reg[4*c]) + HSW'(ph_reg[4*c+1])
                       - HSW'(ph_reg[4*c+2]) - HSW'(ph_reg[4*c+3]);
            ls_next[c] = LSW'(pl_reg[4*c]) + LSW'(pl_reg[4*c+1])
                       - LSW'(pl_reg[4*c+2]) - LSW'(pl_reg[4*c+3]);
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] sum;
        for (int c = 0; c < 3; c++)
        begin
            sum        = (SW'(hs_reg[c]) <<< LW) + SW'(ls_reg[c]) + HALF;
            rn_next[c] = sum[SW-1:DROP];
        end
    end

    always_comb
    begin
        clamped_next = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            if (rn_reg[c] > MAX_V)
            begin
                rot_next[c]  = MAX_V[OUT_WIDTH-1:0];
                clamped_next = 1'b1;
            end
            else if (rn_reg[c] < MIN_V)
            begin
                rot_next[c]  = MIN_V[OUT_WIDTH-1:0];
                clamped_next = 1'b1;
            end
            else
            begin
                rot_next[c] = rn_reg[c][OUT_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            qa_reg <= q_in;
            pa_reg <= pa_next;
        end
        if (en[1])
        begin
            qb_reg <= qa_reg;
            tb_reg <= tb_next;
        end
        if (en[2])
        begin
            ph_reg <= ph_next;
            pl_reg <= pl_next;
        end
        if (en[3])
        begin
            hs_reg <= hs_next;
            ls_reg <= ls_next;
        end
        if (en[4])
        begin
            rn_reg <= rn_next;
        end
        if (en[5])
        begin
            rot_reg     <= rot_next;
            clamped_reg <= clamped_next;
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign rot_x     = rot_reg[COMP_X];
    assign rot_y     = rot_reg[COMP_Y];
    assign rot_z     = rot_reg[COMP_Z];
    assign clamped   = clamped_reg;

    assign at_limit = (rot_x == MAX_V[OUT_WIDTH-1:0]) || (rot_x == MIN_V[OUT_WIDTH-1:0])
                   || (rot_y == MAX_V[OUT_WIDTH-1:0]) || (rot_y == MIN_V[OUT_WIDTH-1:0])
                   || (rot_z == MAX_V[OUT_WIDTH-1:0]) || (rot_z == MIN_V[OUT_WIDTH-1:0]);

    `QVR_ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n, in_stall, (&v_reg) && out_stall)
    `QVR_ASSERT_IMPLIES(a_full_and_stalled, clk, rst_n, (&v_reg) && out_stall, in_stall)
    `QVR_ASSERT_IMPLIES(a_clamp_at_limit, clk, rst_n, out_valid && clamped, at_limit)
    `QVR_ASSERT_NEXT(a_last_stage_fills, clk, rst_n, v_reg[STAGES-2] && en[STAGES-1], out_valid)

endmodule

`default_nettype wire

// ----- tb/quaternion_rotation_checker.sv -----
// Checker for the quaternion vector rotation core: watches both channels,
// predicts each rotation and compares it with the result item that arrives.
// Depends on qvr_pkg for the output width.
module quaternion_rotation_checker #(
    parameter int VEC_WIDTH      = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic signed [QUAT_FRAC_BITS+1:0]     quat_x,
    input  logic signed [QUAT_FRAC_BITS+1:0]     quat_y,
    input  logic signed [QUAT_FRAC_BITS+1:0]     quat_z,
    input  logic signed [QUAT_FRAC_BITS+1:0]     quat_w,
    input  logic signed [VEC_WIDTH-1:0]          vec_x,
    input  logic signed [VEC_WIDTH-1:0]          vec_y,
    input  logic signed [VEC_WIDTH-1:0]          vec_z,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [qvr_pkg::OUT_WIDTH-1:0] rot_x,
    input  logic signed [qvr_pkg::OUT_WIDTH-1:0] rot_y,
    input  logic signed [qvr_pkg::OUT_WIDTH-1:0] rot_z,
    input  logic                                 clamped,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   results_checked,
    output int                                   results_clamped
);

    localparam int DROP_BITS = 2 * QUAT_FRAC_BITS;

    typedef logic signed [127:0] acc_t;
    typedef logic signed [qvr_pkg::OUT_WIDTH-1:0] comp_t;

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
        logic  clamped;
    } rotation_t;

    localparam acc_t ROUND_HALF = acc_t'(1) <<< (DROP_BITS - 1);
    localparam acc_t OUT_MAX    = (acc_t'(1) <<< (qvr_pkg::OUT_WIDTH - 1)) - 1;
    localparam acc_t OUT_MIN    = -(acc_t'(1) <<< (qvr_pkg::OUT_WIDTH - 1));

    rotation_t expected_rotations[$];

    function automatic comp_t round_saturate(input acc_t value, inout logic clip);
        acc_t rounded;
        rounded = (value + ROUND_HALF) >>> DROP_BITS;
        if (rounded > OUT_MAX) begin
            clip = 1'b1;
            return comp_t'(OUT_MAX);
        end
        if (rounded < OUT_MIN) begin
            clip = 1'b1;
            return comp_t'(OUT_MIN);
        end
        return comp_t'(rounded);
    endfunction

    function automatic rotation_t rotate_vector(
        input logic signed [QUAT_FRAC_BITS+1:0] qx, qy, qz, qw,
        input logic signed [VEC_WIDTH-1:0]      ax, ay, az
    );
        acc_t x, y, z, w, vx, vy, vz;
        acc_t tx, ty, tz, tw, rx, ry, rz;
        rotation_t res;
        logic clip;
        x  = acc_t'(qx);
        y  = acc_t'(qy);
        z  = acc_t'(qz);
        w  = acc_t'(qw);
        vx = acc_t'(ax);
        vy = acc_t'(ay);
        vz = acc_t'(az);
        tx = w * vx + y * vz - z * vy;
        ty = w * vy + z * vx - x * vz;
        tz = w * vz + x * vy - y * vx;
        tw = -(x * vx + y * vy + z * vz);
        rx = tx * w + tz * y - (tw * x + ty * z);
        ry = ty * w + tx * z - (tw * y + tz * x);
        rz = tz * w + ty * x - (tw * z + tx * y);
        clip  = 1'b0;
        res.x = round_saturate(rx, clip);
        res.y = round_saturate(ry, clip);
        res.z = round_saturate(rz, clip);
        res.clamped = clip;
        return res;
    endfunction

    initial begin
        fail_count      = 0;
        pending         = 0;
        results_checked = 0;
        results_clamped = 0;
    end

    always @(posedge clk) begin
        rotation_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_rotations.size() == 0) begin
                    $error("result item with no rotation outstanding");
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_rotations.pop_front();
                    results_checked = results_checked + 1;
                    if (clamped)
                        results_clamped = results_clamped + 1;
                    if (rot_x !== want.x) begin
                        $error("rot_x: expected %0d, actual %0d", want.x, rot_x);
                        fail_count = fail_count + 1;
                    end
                    if (rot_y !== want.y) begin
                        $error("rot_y: expected %0d, actual %0d", want.y, rot_y);
                        fail_count = fail_count + 1;
                    end
                    if (rot_z !== want.z) begin
                        $error("rot_z: expected %0d, actual %0d", want.z, rot_z);
                        fail_count = fail_count + 1;
                    end
                    if (clamped !== want.clamped) begin
                        $error("clamped: expected %0d, actual %0d", want.clamped, clamped);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_rotations.push_back(rotate_vector(quat_x, quat_y, quat_z, quat_w,
                                                           vec_x, vec_y, vec_z));
            pending = expected_rotations.size();
        end
    end

endmodule

// ----- tb/quaternion_vector_rotate_core_tb.sv -----
// Top of the testbench for the quaternion vector rotation core: drives
// directed and random items with random idling on both channels and gives
// the verdict. Depends on the core, qvr_pkg and quaternion_rotation_checker.
module quaternion_vector_rotate_core_tb;

    localparam int VEC_WIDTH      = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int QUAT_ONE       = 1 << QUAT_FRAC_BITS;
    localparam int HALF_ROOT_TWO  = 11585;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int HOLD_AFTER     = 400;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 12;
    localparam int CYCLE_LIMIT    = 500000;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_stall;
    logic signed [QUAT_FRAC_BITS+1:0]     quat_x;
    logic signed [QUAT_FRAC_BITS+1:0]     quat_y;
    logic signed [QUAT_FRAC_BITS+1:0]     quat_z;
    logic signed [QUAT_FRAC_BITS+1:0]     quat_w;
    logic signed [VEC_WIDTH-1:0]          vec_x;
    logic signed [VEC_WIDTH-1:0]          vec_y;
    logic signed [VEC_WIDTH-1:0]          vec_z;
    logic                                 out_valid;
    logic                                 out_stall;
    logic signed [qvr_pkg::OUT_WIDTH-1:0] rot_x;
    logic signed [qvr_pkg::OUT_WIDTH-1:0] rot_y;
    logic signed [qvr_pkg::OUT_WIDTH-1:0] rot_z;
    logic                                 clamped;

    int fail_count;
    int pending;
    int results_checked;
    int results_clamped;
    int items_sent;
    int cycle_count;
    logic burst_mode;
    logic hold_done;

    quaternion_vector_rotate_core #(
        .VEC_WIDTH      (VEC_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z),
        .clamped   (clamped)
    );

    quaternion_rotation_checker #(
        .VEC_WIDTH      (VEC_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .quat_x          (quat_x),
        .quat_y          (quat_y),
        .quat_z          (quat_z),
        .quat_w          (quat_w),
        .vec_x           (vec_x),
        .vec_y           (vec_y),
        .vec_z           (vec_z),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .rot_x           (rot_x),
        .rot_y           (rot_y),
        .rot_z           (rot_z),
        .clamped         (clamped),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .results_clamped (results_clamped)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial begin
        cycle_count = 0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d items outstanding.",
                     cycle_count, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] any_word();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [15:0] bounded_word(input int limit);
        return 16'(int'($urandom_range(0, 2 * limit)) - limit);
    endfunction

    function automatic int idle_length();
        int pick;
        if (burst_mode)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(input logic [15:0] qx, qy, qz, qw, vx, vy, vz);
        int gap;
        quat_x   <= qx;
        quat_y   <= qy;
        quat_z   <= qz;
        quat_w   <= qw;
        vec_x    <= vx;
        vec_y    <= vy;
        vec_z    <= vz;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        items_sent = items_sent + 1;
        gap = idle_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial begin
        out_stall <= 1'b0;
        hold_done  = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            int pick;
            int run;
            pick = $urandom_range(0, 99);
            if (!hold_done && items_sent >= HOLD_AFTER) begin
                out_stall <= 1'b1;
                run = HOLD_CYCLES;
                hold_done = 1'b1;
            end else if (pick < 40) begin
                out_stall <= 1'b0;
                run = $urandom_range(1, 20);
            end else if (pick < 48) begin
                out_stall <= 1'b0;
                run = $urandom_range(50, 150);
            end else if (pick < 92) begin
                out_stall <= 1'b1;
                run = $urandom_range(1, 3);
            end else begin
                out_stall <= 1'b1;
                run = $urandom_range(10, 40);
            end
            repeat (run) @(posedge clk);
        end
    end

    initial begin
        int directed_items;
        int pick;
        logic [15:0] qx, qy, qz, qw;
        logic [15:0] sign;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        quat_x     <= '0;
        quat_y     <= '0;
        quat_z     <= '0;
        quat_w     <= '0;
        vec_x      <= '0;
        vec_y      <= '0;
        vec_z      <= '0;
        items_sent  = 0;
        burst_mode  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero quaternion, identity, quarter turns about each axis and half turns about x and y.
        send_item(0, 0, 0, 0, 16'h7fff, 16'h8000, 16'h1234);
        send_item(0, 0, 0, 16'(QUAT_ONE), 16'h7fff, 16'h8000, 0);
        send_item(0, 0, 0, 16'(QUAT_ONE), 16'h8000, 16'h7fff, 16'hffff);
        send_item(0, 0, 16'(HALF_ROOT_TWO), 16'(HALF_ROOT_TWO), 1000, 0, 0);
        send_item(16'(HALF_ROOT_TWO), 0, 0, 16'(HALF_ROOT_TWO), 0, 1000, -2000);
        send_item(0, 16'(HALF_ROOT_TWO), 0, 16'(HALF_ROOT_TWO), 3000, -700, 1000);
        send_item(16'(QUAT_ONE), 0, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff);
        send_item(0, 16'(-QUAT_ONE), 0, 0, 16'h8000, 16'h8000, 16'h8000);
        // Non-unit quaternions, some far enough out to saturate.
        send_item(0, 0, 0, 16'h7fff, 1000, -1000, 20000);
        send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                  16'h8000, 16'h8000, 16'h8000);
        send_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                  16'h7fff, 16'h7fff, 16'h7fff);
        send_item(16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                  16'h8000, 16'h7fff, 16'h8000);
        send_item(16'h8000, 0, 0, 16'h7fff, 0, 16'h7fff, 16'h8000);
        // Exact halves round upwards, for both signs.
        send_item(0, 0, 0, 128, 8192, -8192, 24576);
        send_item(0, 0, 0, 128, -24576, 24576, -8192);
        send_item(0, 0, 0, -128, 8192, 40960, -40960);
        send_item(0, 0, 0, 1, 1, -1, 16'h8000);
        send_item(16'h5555, 16'haaaa, 16'h3333, 16'hcccc,
                  16'h5555, 16'haaaa, 16'h0f0f);
        directed_items = items_sent;

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                send_item(any_word(), any_word(), any_word(), any_word(),
                          any_word(), any_word(), any_word());
            end else if (pick < 70) begin
                send_item(bounded_word(HALF_ROOT_TWO), bounded_word(HALF_ROOT_TWO),
                          bounded_word(HALF_ROOT_TWO), bounded_word(HALF_ROOT_TWO),
                          any_word(), any_word(), any_word());
            end else if (pick < 85) begin
                sign = $urandom_range(0, 1) ? 16'(QUAT_ONE) : 16'(-QUAT_ONE);
                qx = 0;
                qy = 0;
                qz = 0;
                qw = 0;
                case ($urandom_range(0, 3))
                    0: qx = sign;
                    1: qy = sign;
                    2: qz = sign;
                    default: qw = sign;
                endcase
                send_item(qx, qy, qz, qw, any_word(), any_word(), any_word());
            end else begin
                send_item(any_word(), any_word(), any_word(), any_word(),
                          bounded_word(64), bounded_word(64), bounded_word(64));
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items (%0d directed) and checked %0d results, %0d of them saturated.",
                 items_sent, directed_items, results_checked, results_clamped);
        $display("Receiver held off for %0d cycles once; %0d mismatches, %0d left outstanding.",
                 HOLD_CYCLES, fail_count, pending);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- quaternion_vector_rotate_core.f -----
+incdir+rtl
rtl/qvr_pkg.sv
rtl/quaternion_vector_rotate_core.sv
tb/quaternion_rotation_checker.sv
tb/quaternion_vector_rotate_core_tb.sv
